// File: hdl/msds_pkg.sv
// ---------------------------------------------------------------------------
// Motor speed display scanner package
// Item types, command codes, arithmetic constants and the segment table
// shared by the scanner modules.
// ---------------------------------------------------------------------------
package msds_pkg;

   // Command codes carried by an input item.
   localparam logic [1:0] CMD_SAMPLE = 2'd0;
   localparam logic [1:0] CMD_TICK   = 2'd1;
   localparam logic [1:0] CMD_BRAKE  = 2'd2;

   localparam int DIGIT_COUNT_DEFAULT = 4;

   localparam logic [12:0] MV_FULL           = 13'd5000;
   localparam logic [12:0] DUTY_PERIOD       = 13'd8000;
   localparam logic [12:0] BRAKE_DUTY_RESET  = 13'd8000;

   // Reciprocals scaled by 2^18: x/50 for x <= 5000 and x/5 for x <= 40000.
   localparam logic [31:0] RECIP_50 = 32'd5243;
   localparam logic [31:0] RECIP_5  = 32'd52429;
   localparam int          RECIP_SHIFT = 18;

   typedef struct packed {
      logic [1:0]  command;
      logic [12:0] sample_mv;
      logic        forward_pressed;
      logic        backward_pressed;
   } req_type;

   typedef struct packed {
      logic [12:0] drive_duty;
      logic        relay_on;
      logic [3:0]  digit_strobe;
      logic [7:0]  segment_pattern;
      logic [6:0]  shown_value;
   } rsp_type;

   // Segment pattern for one decimal digit.
   function automatic logic [7:0] seg_lookup(input logic [3:0] digit);
      logic [7:0] pattern;
      case (digit)
         4'd0:    pattern = 8'h7E;
         4'd1:    pattern = 8'h0C;
         4'd2:    pattern = 8'hB6;
         4'd3:    pattern = 8'h9E;
         4'd4:    pattern = 8'hCC;
         4'd5:    pattern = 8'hDA;
         4'd6:    pattern = 8'hFA;
         4'd7:    pattern = 8'h4E;
         4'd8:    pattern = 8'hFE;
         4'd9:    pattern = 8'hCE;
         default: pattern = 8'h00;
      endcase
      return pattern;
   endfunction

   // Decimal digit of a 7-bit value at weight 10^exp. The value is below
   // 200, so the hundreds digit is a single compare and everything above
   // it is zero.
   function automatic logic [3:0] digit_select(input logic [6:0] value,
                                               input logic [2:0] exp);
      logic        hundreds;
      logic [6:0]  rest;
      logic [14:0] tens_prod;
      logic [3:0]  tens;
      logic [6:0]  ones;
      logic [3:0]  digit;
      hundreds  = (value >= 7'd100);
      rest      = hundreds ? (value - 7'd100) : value;
      tens_prod = 15'(rest) * 15'd205;
      tens      = tens_prod[14:11];
      ones      = rest - 7'(tens) * 7'd10;
      case (exp)
         3'd0:    digit = ones[3:0];
         3'd1:    digit = tens;
         3'd2:    digit = {3'b000, hundreds};
         default: digit = 4'd0;
      endcase
      return digit;
   endfunction

endpackage

// File: hdl/msds_input_stage.sv
// ---------------------------------------------------------------------------
// Scanner input register
// Holds one accepted item until the core hands its result downstream.
// ---------------------------------------------------------------------------
module msds_input_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  msds_pkg::req_type req_payload,
   input  logic              advance,
   output logic              item_valid,
   output msds_pkg::req_type item_payload
);
   import msds_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   req_type payload_ff;
   logic    take;

   // The register can take a new item when it is empty or its item moves on.
   assign take      = !valid_ff || advance;
   assign req_stall = !take;
   assign valid_in  = take ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && req_valid) begin
         payload_ff <= req_payload;
      end
   end

   assign item_valid   = valid_ff;
   assign item_payload = payload_ff;

endmodule

// File: hdl/msds_core.sv
// ---------------------------------------------------------------------------
// Scanner core
// Holds the display, duty, relay and scan state and the brake duty register,
// and works out the result for the item in the input register.
// ---------------------------------------------------------------------------
module msds_core #(
   parameter int DIGIT_COUNT = msds_pkg::DIGIT_COUNT_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic [12:0]       csr_write_data,
   input  logic              item_valid,
   input  msds_pkg::req_type item_payload,
   input  logic              advance,
   output msds_pkg::rsp_type result
);
   import msds_pkg::*;

   localparam int POS_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(DIGIT_COUNT - 1);

   logic [12:0]      brake_duty_ff;
   logic [POS_W-1:0] scan_pos_ff;
   logic [POS_W-1:0] scan_pos_in;
   logic [6:0]       display_ff;
   logic [6:0]       display_in;
   logic [12:0]      duty_ff;
   logic [12:0]      duty_in;
   logic             relay_ff;
   logic             relay_in;

   logic [12:0] mv_clamped;
   logic [12:0] mv_diff;
   logic [31:0] display_prod;
   logic [31:0] duty_prod;
   logic [12:0] brake_limited;
   logic [POS_W-1:0] exp_pos;
   logic [2:0]  exp_wide;
   logic [3:0]  strobe;
   logic [7:0]  pattern;
   logic        update;

   assign update = item_valid && advance;

   assign mv_clamped    = (item_payload.sample_mv > MV_FULL) ? MV_FULL
                                                             : item_payload.sample_mv;
   assign mv_diff       = MV_FULL - mv_clamped;
   assign display_prod  = 32'(mv_diff) * RECIP_50;
   assign duty_prod     = 32'({mv_clamped, 3'b000}) * RECIP_5;
   assign brake_limited = (brake_duty_ff > DUTY_PERIOD) ? DUTY_PERIOD : brake_duty_ff;

   // Most significant digit comes first, so the weight counts down.
   assign exp_pos  = POS_LAST - scan_pos_ff;
   assign exp_wide = 3'(exp_pos);

   always_comb begin
      display_in  = display_ff;
      duty_in     = duty_ff;
      relay_in    = relay_ff;
      scan_pos_in = scan_pos_ff;
      strobe      = 4'b0000;
      pattern     = 8'h00;
      case (item_payload.command)
         CMD_SAMPLE: begin
            display_in = display_prod[RECIP_SHIFT +: 7];
            duty_in    = duty_prod[RECIP_SHIFT +: 13];
            if (item_payload.forward_pressed) begin
               relay_in = 1'b0;
            end
            if (item_payload.backward_pressed) begin
               relay_in = 1'b1;
            end
         end
         CMD_TICK: begin
            pattern     = seg_lookup(digit_select(display_ff, exp_wide));
            strobe      = (exp_wide < 3'd4) ? (4'b0001 << exp_wide[1:0]) : 4'b0000;
            scan_pos_in = (scan_pos_ff == POS_LAST) ? '0 : scan_pos_ff + 1'b1;
         end
         CMD_BRAKE: begin
            duty_in    = brake_limited;
            display_in = 7'd0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         brake_duty_ff <= BRAKE_DUTY_RESET;
         scan_pos_ff   <= '0;
         display_ff    <= 7'd0;
         duty_ff       <= 13'd0;
         relay_ff      <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            brake_duty_ff <= csr_write_data;
         end
         if (update) begin
            scan_pos_ff <= scan_pos_in;
            display_ff  <= display_in;
            duty_ff     <= duty_in;
            relay_ff    <= relay_in;
         end
      end
   end

   assign result.drive_duty      = duty_in;
   assign result.relay_on        = relay_in;
   assign result.digit_strobe    = strobe;
   assign result.segment_pattern = pattern;
   assign result.shown_value     = display_in;

endmodule

// File: hdl/msds_output_stage.sv
// ---------------------------------------------------------------------------
// Scanner result register
// Holds one finished result until the receiving side takes it.
// ---------------------------------------------------------------------------
module msds_output_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              load_valid,
   input  msds_pkg::rsp_type load_payload,
   output logic              advance,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output msds_pkg::rsp_type rsp_payload
);
   import msds_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type payload_ff;

   assign advance  = !valid_ff || !rsp_stall;
   assign valid_in = advance ? load_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && load_valid) begin
         payload_ff <= load_payload;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = payload_ff;

endmodule

// File: hdl/motor_speed_display_scanner.sv
// ---------------------------------------------------------------------------
// Motor speed display scanner
// Turns converter samples, scan ticks and brake events into drive duty,
// relay level and multiplexed seven-segment digit drive.
// ---------------------------------------------------------------------------
//  Channel   Direction   Handshake              Payload
//  req_      in          req_valid/req_stall    msds_pkg::req_type
//  rsp_      out         rsp_valid/rsp_stall    msds_pkg::rsp_type
//  csr_      in          csr_write_enable       13-bit brake duty
//
// One item per cycle sustained while rsp_ is not stalled; each item gives one
// result, held first in the input register and then in the result register.
// The core computes the result in a single pass of constant multiplies and
// a table lookup between the two registers.
// Synchronous reset clears state; brake duty resets to 8000.
// A stall on rsp_ holds the result register and, once the input register is
// also full, raises req_stall in the same cycle.
// ---------------------------------------------------------------------------
module motor_speed_display_scanner #(
   parameter int DIGIT_COUNT = msds_pkg::DIGIT_COUNT_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic [12:0]       csr_write_data,
   input  logic              req_valid,
   output logic              req_stall,
   input  msds_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output msds_pkg::rsp_type rsp_payload
);
   import msds_pkg::*;

   logic    advance;
   logic    item_valid;
   req_type item_payload;
   rsp_type result;

   msds_input_stage u_input_stage (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_payload  (req_payload),
      .advance      (advance),
      .item_valid   (item_valid),
      .item_payload (item_payload)
   );

   msds_core #(
      .DIGIT_COUNT (DIGIT_COUNT)
   ) u_core (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .item_valid       (item_valid),
      .item_payload     (item_payload),
      .advance          (advance),
      .result           (result)
   );

   msds_output_stage u_output_stage (
      .clock        (clock),
      .reset        (reset),
      .load_valid   (item_valid),
      .load_payload (result),
      .advance      (advance),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload)
   );

endmodule
